[design/ssp_pkg.sv]
// Shared types, constants and helper functions of the serial port register block.
package ssp_pkg;

	localparam int FIFO_DEPTH = 8;
	localparam int WORD_BITS  = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int HALF_DEPTH = FIFO_DEPTH / 2;

	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_SHIFT = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam logic [11:0] OFF_CR0   = 12'h000;
	localparam logic [11:0] OFF_CR1   = 12'h004;
	localparam logic [11:0] OFF_DR    = 12'h008;
	localparam logic [11:0] OFF_SR    = 12'h00c;
	localparam logic [11:0] OFF_CPSR  = 12'h010;
	localparam logic [11:0] OFF_IMSC  = 12'h014;
	localparam logic [11:0] OFF_RIS   = 12'h018;
	localparam logic [11:0] OFF_MIS   = 12'h01c;
	localparam logic [11:0] OFF_DMACR = 12'h020;
	localparam logic [6:0]  ID_PAGE   = 7'h7f;

	localparam int CR1_LOOP   = 0;
	localparam int CR1_ENABLE = 1;

	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == ptr_t'(FIFO_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

	function automatic word_t size_mask_of(input logic [3:0] n);
		word_t m;
		for (int i = 0; i < WORD_BITS; i++) begin
			m[i] = (i <= int'(n));
		end
		return m;
	endfunction

	function automatic logic [3:0] raw_irq(input cnt_t tx_cnt, input cnt_t rx_cnt);
		return {tx_cnt <= cnt_t'(HALF_DEPTH), rx_cnt >= cnt_t'(HALF_DEPTH), 2'b00};
	endfunction

	function automatic logic [7:0] id_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h22;
			3'd1:    b = 8'h10;
			3'd2:    b = 8'h04;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h0d;
			3'd5:    b = 8'hf0;
			3'd6:    b = 8'h05;
			default: b = 8'hb1;
		endcase
		return b;
	endfunction

endpackage

[design/ssp_if.sv]
// Request and response channel interfaces of the serial port register block.
interface ssp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [11:0] reg_offset;
	logic [15:0] write_data;
	logic [15:0] partner_word;

	modport source (output valid, mode, reg_offset, write_data, partner_word, input ready);
	modport sink (input valid, mode, reg_offset, write_data, partner_word, output ready);
endinterface

interface ssp_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        access_error;
	logic        irq_line;
	logic        out_valid;
	logic [15:0] out_word;

	modport source (output valid, read_data, access_error, irq_line, out_valid, out_word,
		input ready);
	modport sink (input valid, read_data, access_error, irq_line, out_valid, out_word,
		output ready);
endinterface

[design/ssp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ssp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/ssp_spi_controller_registers.sv]
// Register block of a synchronous serial port with transmit and receive FIFOs.
// Takes one bus read, bus write or shift tick per clock while the response side does
// not stall; each transfer gives one response, registered through stages s1 and s2.
// The FIFO words live in two RAMs with a registered read; a shift reads
// the TX RAM at acceptance and writes the RX RAM from stage s1, and a data read
// that meets that pending write takes the word from a bypass path.
module ssp_spi_controller_registers
	import ssp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ssp_req_if.sink   req,
	ssp_rsp_if.source rsp
);

	logic [15:0] ctrl0_q;
	logic [3:0]  ctrl1_q;
	logic [7:0]  prescale_q;
	logic [3:0]  int_mask_q;
	word_t       size_mask_q;
	ptr_t        tx_wr_q, tx_rd_q, rx_wr_q, rx_rd_q;
	cnt_t        tx_cnt_q, rx_cnt_q;

	logic        valid_s1;
	logic [15:0] rd_data_s1;
	logic        err_s1, irq_s1, pop_s1, shift_s1, loop_s1, fwd_hit_s1;
	word_t       partner_s1, mask_s1, fwd_data_s1;
	ptr_t        rx_waddr_s1;

	logic        valid_s2;
	logic [15:0] read_data_s2, out_word_s2;
	logic        err_s2, irq_s2, out_valid_s2;

	logic        adv_s1, acc;
	mode_t       mode;
	logic [11:0] off;
	logic        is_read, is_write, is_shift;
	logic        pop, push, shift;
	cnt_t        tx_cnt_d, rx_cnt_d;
	logic [3:0]  int_mask_d;
	logic [15:0] rd_data_d;
	logic        err_d;
	logic [4:0]  status;
	word_t       tx_rdata, rx_rdata, rx_wdata;
	logic        rx_we;

	assign adv_s1    = valid_s1 & (~valid_s2 | rsp.ready);
	assign req.ready = ~valid_s1 | adv_s1;
	assign acc       = req.valid & req.ready;

	assign mode     = mode_t'(req.mode);
	assign off      = req.reg_offset;
	assign is_read  = (mode == MODE_READ);
	assign is_write = (mode == MODE_WRITE);
	assign is_shift = (mode == MODE_SHIFT);

	assign pop   = acc & is_read & (off == OFF_DR) & (rx_cnt_q != '0);
	assign push  = acc & is_write & (off == OFF_DR) & (tx_cnt_q < cnt_t'(FIFO_DEPTH));
	assign shift = acc & is_shift & ctrl1_q[CR1_ENABLE] & (tx_cnt_q != '0)
		& (rx_cnt_q < cnt_t'(FIFO_DEPTH));

	assign tx_cnt_d = cnt_t'(tx_cnt_q + cnt_t'(push) - cnt_t'(shift));
	assign rx_cnt_d = cnt_t'(rx_cnt_q + cnt_t'(shift) - cnt_t'(pop));

	assign int_mask_d = (acc & is_write & (off == OFF_IMSC)) ? req.write_data[3:0] : int_mask_q;

	assign status = {tx_cnt_q != '0, rx_cnt_q >= cnt_t'(FIFO_DEPTH), rx_cnt_q != '0,
		tx_cnt_q < cnt_t'(FIFO_DEPTH), tx_cnt_q == '0};

	always_comb begin
		rd_data_d = '0;
		err_d     = 1'b0;
		if (is_read) begin
			unique case (off)
				OFF_CR0:   rd_data_d = ctrl0_q;
				OFF_CR1:   rd_data_d = {12'd0, ctrl1_q};
				OFF_DR:    rd_data_d = '0;
				OFF_SR:    rd_data_d = {11'd0, status};
				OFF_CPSR:  rd_data_d = {8'd0, prescale_q};
				OFF_IMSC:  rd_data_d = {12'd0, int_mask_q};
				OFF_RIS:   rd_data_d = {12'd0, raw_irq(tx_cnt_q, rx_cnt_q)};
				OFF_MIS:   rd_data_d = {12'd0, raw_irq(tx_cnt_q, rx_cnt_q) & int_mask_q};
				OFF_DMACR: rd_data_d = '0;
				default: begin
					if (off[11:5] == ID_PAGE) begin
						rd_data_d = {8'd0, id_byte(off[4:2])};
					end else begin
						err_d = 1'b1;
					end
				end
			endcase
		end
	end

	ssp_ram #(.WIDTH(WORD_BITS), .DEPTH(FIFO_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (push),
		.waddr (tx_wr_q),
		.wdata (word_t'(req.write_data) & size_mask_q),
		.re    (shift),
		.raddr (tx_rd_q),
		.rdata (tx_rdata)
	);

	assign rx_we    = adv_s1 & shift_s1;
	assign rx_wdata = loop_s1 ? (tx_rdata & mask_s1) : partner_s1;

	ssp_ram #(.WIDTH(WORD_BITS), .DEPTH(FIFO_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_waddr_s1),
		.wdata (rx_wdata),
		.re    (pop),
		.raddr (rx_rd_q),
		.rdata (rx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl0_q     <= '0;
			ctrl1_q     <= '0;
			prescale_q  <= '0;
			int_mask_q  <= '0;
			size_mask_q <= '0;
			tx_wr_q     <= '0;
			tx_rd_q     <= '0;
			tx_cnt_q    <= '0;
			rx_wr_q     <= '0;
			rx_rd_q     <= '0;
			rx_cnt_q    <= '0;
		end else begin
			if (acc & is_write) begin
				unique case (off)
					OFF_CR0: begin
						ctrl0_q     <= req.write_data;
						size_mask_q <= size_mask_of(req.write_data[3:0]);
					end
					OFF_CR1:  ctrl1_q    <= req.write_data[3:0];
					OFF_CPSR: prescale_q <= req.write_data[7:0];
					default:  ;
				endcase
			end
			int_mask_q <= int_mask_d;
			tx_cnt_q   <= tx_cnt_d;
			rx_cnt_q   <= rx_cnt_d;
			if (push) begin
				tx_wr_q <= next_ptr(tx_wr_q);
			end
			if (shift) begin
				tx_rd_q <= next_ptr(tx_rd_q);
				rx_wr_q <= next_ptr(rx_wr_q);
			end
			if (pop) begin
				rx_rd_q <= next_ptr(rx_rd_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_data_s1  <= rd_data_d;
			err_s1      <= err_d;
			irq_s1      <= |(raw_irq(tx_cnt_d, rx_cnt_d) & int_mask_d);
			pop_s1      <= pop;
			shift_s1    <= shift;
			loop_s1     <= ctrl1_q[CR1_LOOP];
			partner_s1  <= word_t'(req.partner_word) & size_mask_q;
			mask_s1     <= size_mask_q;
			rx_waddr_s1 <= rx_wr_q;
			fwd_hit_s1  <= rx_we & (rx_waddr_s1 == rx_rd_q);
			fwd_data_s1 <= rx_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data_s2 <= pop_s1 ? 16'(fwd_hit_s1 ? fwd_data_s1 : rx_rdata) : rd_data_s1;
			err_s2       <= err_s1;
			irq_s2       <= irq_s1;
			out_valid_s2 <= shift_s1 & ~loop_s1;
			out_word_s2  <= (shift_s1 & ~loop_s1) ? 16'(tx_rdata) : 16'd0;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.read_data    = read_data_s2;
	assign rsp.access_error = err_s2;
	assign rsp.irq_line     = irq_s2;
	assign rsp.out_valid    = out_valid_s2;
	assign rsp.out_word     = out_word_s2;

endmodule

[design/ssp_checker.sv]
// Port-level assertions of the serial port register block and their binding.
module ssp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] read_data,
	input logic        access_error,
	input logic        out_valid,
	input logic [15:0] out_word
);

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && access_error |-> read_data == 16'd0 && !out_valid)
		else $error("access error with nonzero payload");

	a_shift_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && out_valid |-> read_data == 16'd0 && !access_error)
		else $error("shift transfer carries read data");

	a_word_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !out_valid |-> out_word == 16'd0)
		else $error("out_word set without out_valid");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(out_word))
		else $error("stalled response changed");

endmodule

bind ssp_spi_controller_registers ssp_checker u_ssp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.read_data    (rsp.read_data),
	.access_error (rsp.access_error),
	.out_valid    (rsp.out_valid),
	.out_word     (rsp.out_word)
);

[verif/ssp_spi_controller_registers_tb.sv]
// Self-checking testbench of the serial port register block: bus accesses and shift ticks.
module ssp_spi_controller_registers_tb
	import ssp_pkg::*;
();

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_ITEMS = 222;

	localparam int SR_TX_EMPTY = 0;
	localparam int SR_TX_NOT_FULL = 1;
	localparam int SR_RX_NOT_EMPTY = 2;
	localparam int SR_RX_FULL = 3;
	localparam int SR_BUSY = 4;
	localparam int IRQ_RX_HALF = 2;
	localparam int IRQ_TX_HALF = 3;
	localparam logic [63:0] ID_BYTES = 64'h22_10_04_00_0d_f0_05_b1;

	typedef struct packed {
		mode_t       mode;
		logic [11:0] reg_offset;
		word_t       write_data;
		word_t       partner_word;
	} port_access_t;

	typedef struct packed {
		word_t read_data;
		logic  access_error;
		logic  irq_line;
		logic  out_valid;
		word_t out_word;
	} port_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ssp_req_if req();
	ssp_rsp_if rsp();

	ssp_spi_controller_registers dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	port_access_t port_accesses[$];
	port_result_t port_results[$];
	port_result_t due;
	int           queued_total = 0;
	int           mismatches = 0;
	int           send_idle_pct = 0;
	int           recv_stall_pct = 0;
	int           hold_requests = 0;
	int           holds_done;
	int           hold_left;
	int           quiet_cycles;

	word_t        cr0_reg = '0;
	logic [3:0]   cr1_reg = '0;
	logic [7:0]   prescale_reg = '0;
	logic [3:0]   irq_mask = '0;
	word_t        word_mask = '0;
	word_t        tx_words [FIFO_DEPTH];
	word_t        rx_words [FIFO_DEPTH];
	ptr_t         tx_wr_slot = '0;
	ptr_t         rx_wr_slot = '0;
	cnt_t         tx_fill = '0;
	cnt_t         rx_fill = '0;

	function automatic ptr_t slot_after(input ptr_t p);
		return ptr_t'((int'(p) + 1) % FIFO_DEPTH);
	endfunction

	function automatic ptr_t oldest_slot(input ptr_t wr, input cnt_t fill);
		return ptr_t'((int'(wr) + FIFO_DEPTH - int'(fill)) % FIFO_DEPTH);
	endfunction

	function automatic logic [3:0] fifo_level_irqs();
		logic [3:0] raw;
		raw = '0;
		raw[IRQ_RX_HALF] = int'(rx_fill) >= FIFO_DEPTH / 2;
		raw[IRQ_TX_HALF] = int'(tx_fill) <= FIFO_DEPTH / 2;
		return raw;
	endfunction

	function automatic port_result_t apply_port_access(input port_access_t a);
		port_result_t r;
		word_t        w;
		logic [16:0]  wide_mask;
		r = '0;
		case (a.mode)
			MODE_READ: begin
				case (a.reg_offset)
					OFF_CR0:   r.read_data = cr0_reg;
					OFF_CR1:   r.read_data = word_t'(cr1_reg);
					OFF_DR: begin
						if (rx_fill != 0) begin
							r.read_data = rx_words[oldest_slot(rx_wr_slot, rx_fill)];
							rx_fill = rx_fill - 1'b1;
						end
					end
					OFF_SR: begin
						r.read_data[SR_TX_EMPTY] = tx_fill == 0;
						r.read_data[SR_TX_NOT_FULL] = int'(tx_fill) < FIFO_DEPTH;
						r.read_data[SR_RX_NOT_EMPTY] = rx_fill != 0;
						r.read_data[SR_RX_FULL] = int'(rx_fill) >= FIFO_DEPTH;
						r.read_data[SR_BUSY] = tx_fill != 0;
					end
					OFF_CPSR:  r.read_data = word_t'(prescale_reg);
					OFF_IMSC:  r.read_data = word_t'(irq_mask);
					OFF_RIS:   r.read_data = word_t'(fifo_level_irqs());
					OFF_MIS:   r.read_data = word_t'(fifo_level_irqs() & irq_mask);
					OFF_DMACR: r.read_data = '0;
					default: begin
						if (a.reg_offset[11:5] == ID_PAGE)
							r.read_data = word_t'(ID_BYTES[8 * (7 - int'(a.reg_offset[4:2])) +: 8]);
						else
							r.access_error = 1'b1;
					end
				endcase
			end
			MODE_WRITE: begin
				case (a.reg_offset)
					OFF_CR0: begin
						cr0_reg = a.write_data;
						wide_mask = (17'd1 << ({1'b0, a.write_data[3:0]} + 5'd1)) - 17'd1;
						word_mask = wide_mask[15:0];
					end
					OFF_CR1:  cr1_reg = a.write_data[3:0];
					OFF_DR: begin
						if (int'(tx_fill) < FIFO_DEPTH) begin
							tx_words[tx_wr_slot] = a.write_data & word_mask;
							tx_wr_slot = slot_after(tx_wr_slot);
							tx_fill = tx_fill + 1'b1;
						end
					end
					OFF_CPSR: prescale_reg = a.write_data[7:0];
					OFF_IMSC: irq_mask = a.write_data[3:0];
					default:  ;
				endcase
			end
			MODE_SHIFT: begin
				if (cr1_reg[CR1_ENABLE] && tx_fill != 0 && int'(rx_fill) < FIFO_DEPTH) begin
					w = tx_words[oldest_slot(tx_wr_slot, tx_fill)];
					tx_fill = tx_fill - 1'b1;
					if (!cr1_reg[CR1_LOOP]) begin
						r.out_valid = 1'b1;
						r.out_word = w;
						w = a.partner_word;
					end
					rx_words[rx_wr_slot] = w & word_mask;
					rx_wr_slot = slot_after(rx_wr_slot);
					rx_fill = rx_fill + 1'b1;
				end
			end
			default: ;
		endcase
		r.irq_line = |(fifo_level_irqs() & irq_mask);
		return r;
	endfunction

	task automatic add_access(input mode_t m, input logic [11:0] off, input word_t wd,
		input word_t pw);
		port_accesses.push_back('{m, off, wd, pw});
		queued_total++;
	endtask

	function automatic port_access_t random_access();
		port_access_t a;
		int           pick;
		a.mode = MODE_READ;
		a.reg_offset = OFF_DR;
		a.write_data = word_t'($urandom_range(0, 65535));
		a.partner_word = word_t'($urandom_range(0, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			a.mode = mode_t'($urandom_range(0, 3));
			a.reg_offset = 12'($urandom_range(0, 4095));
		end else if (pick < 30) begin
			a.mode = MODE_WRITE;
		end else if (pick < 52) begin
			a.mode = MODE_READ;
		end else if (pick < 76) begin
			a.mode = MODE_SHIFT;
		end else if (pick < 86) begin
			case ($urandom_range(0, 9))
				0: a.reg_offset = OFF_CR0;
				1: a.reg_offset = OFF_CR1;
				2: a.reg_offset = OFF_SR;
				3: a.reg_offset = OFF_CPSR;
				4: a.reg_offset = OFF_IMSC;
				5: a.reg_offset = OFF_RIS;
				6: a.reg_offset = OFF_MIS;
				7: a.reg_offset = OFF_DMACR;
				default: a.reg_offset = {ID_PAGE, 5'($urandom_range(0, 31))};
			endcase
		end else if (pick < 94) begin
			a.mode = MODE_WRITE;
			case ($urandom_range(0, 3))
				0: a.reg_offset = OFF_CR0;
				1: begin
					a.reg_offset = OFF_CR1;
					a.write_data[CR1_ENABLE] = $urandom_range(0, 3) != 0;
				end
				2: a.reg_offset = OFF_CPSR;
				default: a.reg_offset = OFF_IMSC;
			endcase
		end else begin
			a.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
			a.reg_offset = 12'($urandom_range(12'h024, 12'hfdf));
		end
		return a;
	endfunction

	task automatic add_random_run();
		port_access_t a;
		int           n;
		n = $urandom_range(1, 10);
		case ($urandom_range(0, 5))
			0: repeat (n) add_access(MODE_WRITE, OFF_DR, word_t'($urandom_range(0, 65535)), '0);
			1: repeat (n) add_access(MODE_SHIFT, OFF_DR, '0, word_t'($urandom_range(0, 65535)));
			2: repeat (n) add_access(MODE_READ, OFF_DR, '0, '0);
			default: begin
				a = random_access();
				add_access(a.mode, a.reg_offset, a.write_data, a.partner_word);
			end
		endcase
	endtask

	task automatic wait_drained();
		while (port_accesses.size() != 0 || port_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= MODE_NONE;
			req.reg_offset <= '0;
			req.write_data <= '0;
			req.partner_word <= '0;
		end else begin
			if (req.valid && req.ready)
				port_results.push_back(apply_port_access(port_accesses.pop_front()));
			if (!req.valid || req.ready) begin
				if (port_accesses.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
					req.valid <= 1'b1;
					req.mode <= port_accesses[0].mode;
					req.reg_offset <= port_accesses[0].reg_offset;
					req.write_data <= port_accesses[0].write_data;
					req.partner_word <= port_accesses[0].partner_word;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			rsp.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= $urandom_range(1, 100) > recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (port_results.size() == 0) begin
				$display("%0t: transfer expected none, actual data %h err %b irq %b out %b %h",
					$time, rsp.read_data, rsp.access_error, rsp.irq_line, rsp.out_valid,
					rsp.out_word);
				mismatches++;
			end else begin
				due = port_results.pop_front();
				check_field("read_data", due.read_data, rsp.read_data);
				check_field("access_error", 16'(due.access_error), 16'(rsp.access_error));
				check_field("irq_line", 16'(due.irq_line), 16'(rsp.irq_line));
				check_field("out_valid", 16'(due.out_valid), 16'(rsp.out_valid));
				check_field("out_word", due.out_word, rsp.out_word);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_access(MODE_READ, OFF_CR0, '0, '0);
		add_access(MODE_READ, OFF_SR, '0, '0);
		add_access(MODE_READ, OFF_RIS, '0, '0);
		add_access(MODE_READ, 12'h024, '0, '0);
		add_access(MODE_READ, 12'h002, '0, '0);
		add_access(MODE_READ, {ID_PAGE, 5'h00}, '0, '0);
		add_access(MODE_READ, {ID_PAGE, 5'h1f}, '0, '0);
		add_access(MODE_WRITE, OFF_DR, 16'hffff, '0);
		add_access(MODE_WRITE, OFF_CR0, 16'hffff, '0);
		add_access(MODE_WRITE, OFF_CR1, 16'h0002, '0);
		add_access(MODE_WRITE, OFF_IMSC, 16'hffff, '0);
		add_access(MODE_WRITE, OFF_CPSR, 16'hffff, '0);
		add_access(MODE_WRITE, OFF_DMACR, 16'hffff, '0);
		add_access(MODE_WRITE, OFF_SR, 16'hffff, '0);
		add_access(MODE_WRITE, OFF_DR, 16'hffff, '0);
		add_access(MODE_SHIFT, '0, '0, 16'hffff);
		add_access(MODE_SHIFT, '0, '0, 16'h0000);
		add_access(MODE_SHIFT, '0, '0, 16'h5a5a);
		add_access(MODE_WRITE, OFF_CR1, 16'h0003, '0);
		add_access(MODE_WRITE, OFF_DR, 16'h1234, '0);
		add_access(MODE_SHIFT, '0, '0, 16'ha5a5);
		repeat (4) add_access(MODE_READ, OFF_DR, '0, '0);
		add_access(MODE_NONE, OFF_DR, 16'hffff, 16'hffff);
		add_access(MODE_WRITE, OFF_CR0, 16'h0000, '0);
		add_access(MODE_WRITE, OFF_CR1, 16'h0000, '0);
		add_access(MODE_WRITE, OFF_DR, 16'hffff, '0);
		add_access(MODE_SHIFT, '0, '0, 16'hffff);
		wait_drained();

		// hold off responses at the start of a sequence that drives both FIFOs to full and past it
		hold_requests++;
		add_access(MODE_WRITE, OFF_CR0, 16'h000f, '0);
		add_access(MODE_WRITE, OFF_CR1, 16'h0002, '0);
		add_access(MODE_WRITE, OFF_IMSC, 16'h000c, '0);
		repeat (10) add_access(MODE_WRITE, OFF_DR, word_t'($urandom_range(0, 65535)), '0);
		repeat (10) add_access(MODE_SHIFT, '0, '0, word_t'($urandom_range(0, 65535)));
		repeat (9) add_access(MODE_WRITE, OFF_DR, word_t'($urandom_range(0, 65535)), '0);
		repeat (2) add_access(MODE_SHIFT, '0, '0, word_t'($urandom_range(0, 65535)));
		add_access(MODE_READ, OFF_SR, '0, '0);
		repeat (10) add_access(MODE_READ, OFF_DR, '0, '0);
		repeat (8) add_access(MODE_SHIFT, '0, '0, word_t'($urandom_range(0, 65535)));
		repeat (8) add_access(MODE_READ, OFF_DR, '0, '0);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 57; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 57; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			while (queued_total < 62 + (phase + 1) * PHASE_ITEMS)
				add_random_run();
			wait_drained();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0 && port_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			if (port_results.size() != 0)
				$display("%0t: %0d transfers never arrived", $time, port_results.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
